>>> sv/dxt_pkg.sv
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, register indexes and helper functions for the DXT1/DXT3
// block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALPHA_MODE   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_BLOCK_HEIGHT = 2'd2;

    localparam logic [2:0] BLOCK_DIM_MAX = 3'd4;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [1:0] IDX_BLACK     = 2'd3;

    // Three 8-bit channels, channel 0 at index 0
    typedef logic [2:0][7:0] rgb_t;

    // Decoded palette of one block, travels to the row sequencer
    typedef struct packed {
        rgb_t [3:0]   pal;
        logic         four;
        logic [31:0]  index_word;
        logic [63:0]  alpha_word;
    } pal_item_t;

    // Clip a block dimension to 1..4
    function automatic logic [2:0] clip_size(input logic [2:0] v);
        logic [2:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > BLOCK_DIM_MAX) begin
            r = BLOCK_DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Expand a 565 word to three 8-bit channels by left shift
    function automatic rgb_t widen(input logic [15:0] c);
        rgb_t r;
        r[0] = {c[15:11], 3'b000};
        r[1] = {c[10:5], 2'b00};
        r[2] = {c[4:0], 3'b000};
        return r;
    endfunction

endpackage

>>> sv/dxt_palette.sv
// ----------------------------------------------------------------------------
// dxt_palette
// Two-stage palette builder: stage one widens the endpoints and forms the
// blend sums, stage two divides by three (or halves) and selects the palette entries.
// ----------------------------------------------------------------------------
module dxt_palette
    import dxt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] endpoint_a,
    input  logic [15:0] endpoint_b,
    input  logic [31:0] index_word,
    input  logic [63:0] alpha_word,
    output logic        out_valid,
    input  logic        out_ready,
    output pal_item_t   out_item
);

    // x / 3 for x < 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = {11'd0, x} * 21'd683;
        return p[18:11];
    endfunction

    // Stage 1 registers
    logic             s1_valid_reg;
    rgb_t             s1_a_reg;
    rgb_t             s1_b_reg;
    logic [2:0][9:0]  s1_sum21_reg;
    logic [2:0][9:0]  s1_sum12_reg;
    logic [2:0][8:0]  s1_sum11_reg;
    logic             s1_four_reg;
    logic [31:0]      s1_idx_reg;
    logic [63:0]      s1_alpha_reg;

    // Stage 2 registers
    logic             s2_valid_reg;
    pal_item_t        s2_item_reg;
    pal_item_t        s2_item_next;

    logic s1_ready;
    logic s2_ready;
    rgb_t wa;
    rgb_t wb;
    logic [2:0][9:0] sum21_next;
    logic [2:0][9:0] sum12_next;
    logic [2:0][8:0] sum11_next;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign wa = widen(endpoint_a);
    assign wb = widen(endpoint_b);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum21_next[ch] = {1'b0, wa[ch], 1'b0} + {2'b00, wb[ch]};
            sum12_next[ch] = {2'b00, wa[ch]} + {1'b0, wb[ch], 1'b0};
            sum11_next[ch] = {1'b0, wa[ch]} + {1'b0, wb[ch]};
        end
    end

    always_comb begin
        s2_item_next.four       = s1_four_reg;
        s2_item_next.index_word = s1_idx_reg;
        s2_item_next.alpha_word = s1_alpha_reg;
        s2_item_next.pal[0]     = s1_a_reg;
        s2_item_next.pal[1]     = s1_b_reg;
        for (int ch = 0; ch < 3; ch++) begin
            if (s1_four_reg) begin
                s2_item_next.pal[2][ch] = div3(s1_sum21_reg[ch]);
                s2_item_next.pal[3][ch] = div3(s1_sum12_reg[ch]);
            end else begin
                s2_item_next.pal[2][ch] = s1_sum11_reg[ch][8:1];
                s2_item_next.pal[3][ch] = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
        if (s1_ready && in_valid) begin
            s1_a_reg     <= wa;
            s1_b_reg     <= wb;
            s1_sum21_reg <= sum21_next;
            s1_sum12_reg <= sum12_next;
            s1_sum11_reg <= sum11_next;
            s1_four_reg  <= (endpoint_a > endpoint_b);
            s1_idx_reg   <= index_word;
            s1_alpha_reg <= alpha_word;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

>>> sv/dxt_block_decoder.sv
// ----------------------------------------------------------------------------
// dxt_block_decoder
// DXT1/DXT3 block decompression into rows of four 32-bit pixels.
// ----------------------------------------------------------------------------
// A compressed block enters through a two-stage palette builder, then a row
// sequencer emits one row item per cycle into an output register while the
// output side is not stalled. The sequencer holds a block for block_height
// row items (1 to 4, after clipping) and can take the next block as it emits
// the last row of the current one. Configuration is sampled live and must
// only change while no block is in flight.
module dxt_block_decoder
    import dxt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    // compressed block in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_endpoint_a,
    input  logic [15:0] s_endpoint_b,
    input  logic [31:0] s_index_word,
    input  logic [63:0] s_alpha_word,
    // pixel rows out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_zero,
    output logic [31:0] m_pixel_one,
    output logic [31:0] m_pixel_two,
    output logic [31:0] m_pixel_three,
    output logic [1:0]  m_row_number,
    output logic        m_last_row
);

    logic       cfg_alpha_mode_reg;
    logic [2:0] cfg_width_reg;
    logic [2:0] cfg_height_reg;

    logic       pal_valid;
    logic       pal_ready;
    pal_item_t  pal_item;

    // Row sequencer
    logic       blk_valid_reg;
    rgb_t [3:0] blk_pal_reg;
    logic       blk_four_reg;
    logic [31:0] blk_idx_reg;
    logic [63:0] blk_alpha_reg;
    logic [1:0] row_reg;

    // Output register
    logic             m_valid_reg;
    logic [3:0][31:0] m_pixel_reg;
    logic [1:0]       m_row_reg;
    logic             m_last_reg;

    logic [2:0]       bw;
    logic [2:0]       bh;
    logic [1:0]       bh_last;
    logic             out_free;
    logic             emit;
    logic             row_last;
    logic             blk_ready;
    logic [3:0][31:0] pixel_next;

    dxt_palette u_palette (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .endpoint_a (s_endpoint_a),
        .endpoint_b (s_endpoint_b),
        .index_word (s_index_word),
        .alpha_word (s_alpha_word),
        .out_valid  (pal_valid),
        .out_ready  (pal_ready),
        .out_item   (pal_item)
    );

    assign bw        = clip_size(cfg_width_reg);
    assign bh        = clip_size(cfg_height_reg);
    assign bh_last   = 2'(bh - 3'd1);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = blk_valid_reg && out_free;
    assign row_last  = (row_reg == bh_last);
    assign blk_ready = !blk_valid_reg || (emit && row_last);
    assign pal_ready = blk_ready;

    // Build the current row; alpha nibble i of the shifted word belongs to pixel i
    always_comb begin
        logic [1:0] k;
        logic [7:0] al;
        for (int i = 0; i < 4; i++) begin
            k  = blk_idx_reg[2*i +: 2];
            if (cfg_alpha_mode_reg) begin
                al = {blk_alpha_reg[4*i +: 4], 4'b0000};
            end else if (k == IDX_BLACK && !blk_four_reg) begin
                al = 8'd0;
            end else begin
                al = ALPHA_OPAQUE;
            end
            if (3'(i) < bw) begin
                pixel_next[i] = {al, blk_pal_reg[k][2], blk_pal_reg[k][1], blk_pal_reg[k][0]};
            end else begin
                pixel_next[i] = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_alpha_mode_reg <= 1'b0;
            cfg_width_reg      <= 3'd4;
            cfg_height_reg     <= 3'd4;
            blk_valid_reg      <= 1'b0;
            row_reg            <= 2'd0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_write_enable) begin
                unique case (cfg_index)
                    CFG_ALPHA_MODE:   cfg_alpha_mode_reg <= cfg_data[0];
                    CFG_BLOCK_WIDTH:  cfg_width_reg      <= cfg_data;
                    CFG_BLOCK_HEIGHT: cfg_height_reg     <= cfg_data;
                    default: ;
                endcase
            end

            if (blk_ready) begin
                blk_valid_reg <= pal_valid;
                row_reg       <= 2'd0;
            end else if (emit) begin
                row_reg <= row_reg + 2'd1;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // payload
        if (blk_ready && pal_valid) begin
            blk_pal_reg   <= pal_item.pal;
            blk_four_reg  <= pal_item.four;
            blk_idx_reg   <= pal_item.index_word;
            blk_alpha_reg <= pal_item.alpha_word;
        end else if (emit) begin
            // advance to the next row byte and drop the nibbles just used
            blk_idx_reg   <= blk_idx_reg >> 8;
            blk_alpha_reg <= blk_alpha_reg >> {bw, 2'b00};
        end

        if (emit) begin
            m_pixel_reg <= pixel_next;
            m_row_reg   <= row_reg;
            m_last_reg  <= row_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_zero  = m_pixel_reg[0];
    assign m_pixel_one   = m_pixel_reg[1];
    assign m_pixel_two   = m_pixel_reg[2];
    assign m_pixel_three = m_pixel_reg[3];
    assign m_row_number  = m_row_reg;
    assign m_last_row    = m_last_reg;

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_valid_reg |-> ({1'b0, row_reg} < bh))
        else $error("row counter beyond block height");

    a_last_row_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_row_reg == bh_last)))
        else $error("last_row flag does not match row number");

    a_unused_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && bw != BLOCK_DIM_MAX) |-> (m_pixel_reg[3] == 32'd0))
        else $error("pixel slot beyond block width not zero");

    a_block_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && row_last && !pal_valid) |=> !blk_valid_reg)
        else $error("block not retired after its last row");

    a_first_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_ready && pal_valid) |=> (blk_valid_reg && row_reg == 2'd0))
        else $error("new block does not start at row zero");

endmodule

>>> tb/dxt_block_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_block_decoder_checker
// Watches the configuration port and both channels of the block decoder.
// Each accepted compressed block is decoded here into its expected pixel
// rows, and every row leaving the decoder is compared field by field with
// the oldest expected row.
// ----------------------------------------------------------------------------
module dxt_block_decoder_checker
    import dxt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_endpoint_a,
    input  logic [15:0] s_endpoint_b,
    input  logic [31:0] s_index_word,
    input  logic [63:0] s_alpha_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_pixel_zero,
    input  logic [31:0] m_pixel_one,
    input  logic [31:0] m_pixel_two,
    input  logic [31:0] m_pixel_three,
    input  logic [1:0]  m_row_number,
    input  logic        m_last_row,
    output int          mismatch_count,
    output int          rows_pending
);

    typedef struct packed {
        logic [3:0][31:0] px;
        logic [1:0]       row;
        logic             last;
    } pixel_row_t;

    pixel_row_t expected_rows[$];
    logic       explicit_alpha;
    logic [2:0] width_reg;
    logic [2:0] height_reg;
    int         fail_tally = 0;

    function automatic logic [2:0] effective_dim(input logic [2:0] v);
        if (v == 3'd0) begin
            return 3'd1;
        end else if (v > BLOCK_DIM_MAX) begin
            return BLOCK_DIM_MAX;
        end
        return v;
    endfunction

    // Widen one 565 channel to eight bits by shifting, no replication
    function automatic logic [7:0] expand_channel(input logic [15:0] c, input int ch);
        case (ch)
            0:       return {c[15:11], 3'b000};
            1:       return {c[10:5], 2'b00};
            default: return {c[4:0], 3'b000};
        endcase
    endfunction

    task automatic decode_block(input logic [15:0] ea, input logic [15:0] eb,
                                input logic [31:0] idx, input logic [63:0] alpha);
        logic [7:0] pal [4][3];
        int         a;
        int         b;
        bit         four_color;
        logic [2:0] bw;
        logic [2:0] bh;
        int         nib;
        logic [7:0] row_bits;
        logic [1:0] k;
        logic [7:0] al;
        pixel_row_t r;
        four_color = (ea > eb);
        for (int ch = 0; ch < 3; ch++) begin
            a = expand_channel(ea, ch);
            b = expand_channel(eb, ch);
            pal[0][ch] = 8'(a);
            pal[1][ch] = 8'(b);
            if (four_color) begin
                pal[2][ch] = 8'((2 * a + b) / 3);
                pal[3][ch] = 8'((a + 2 * b) / 3);
            end else begin
                pal[2][ch] = 8'((a + b) / 2);
                pal[3][ch] = 8'd0;
            end
        end
        bw  = effective_dim(width_reg);
        bh  = effective_dim(height_reg);
        nib = 0;
        for (int j = 0; j < int'(bh); j++) begin
            row_bits = idx[8 * j +: 8];
            r = '0;
            for (int i = 0; i < 4; i++) begin
                if (i < int'(bw)) begin
                    k = row_bits[2 * i +: 2];
                    // explicit alpha consumes one nibble per emitted pixel
                    if (explicit_alpha) begin
                        al = {alpha[4 * nib +: 4], 4'b0000};
                        nib++;
                    end else begin
                        al = (k == IDX_BLACK && !four_color) ? 8'd0 : ALPHA_OPAQUE;
                    end
                    r.px[i] = {al, pal[k][2], pal[k][1], pal[k][0]};
                end
            end
            r.row  = 2'(j);
            r.last = (j + 1 == int'(bh));
            expected_rows.push_back(r);
        end
    endtask

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        pixel_row_t got;
        pixel_row_t want;
        if (!aresetn) begin
            explicit_alpha = 1'b0;
            width_reg      = BLOCK_DIM_MAX;
            height_reg     = BLOCK_DIM_MAX;
            expected_rows.delete();
        end else begin
            if (cfg_write_enable) begin
                case (cfg_index)
                    CFG_ALPHA_MODE:   explicit_alpha = cfg_data[0];
                    CFG_BLOCK_WIDTH:  width_reg = cfg_data;
                    CFG_BLOCK_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.px   = {m_pixel_three, m_pixel_two, m_pixel_one, m_pixel_zero};
                got.row  = m_row_number;
                got.last = m_last_row;
                if (expected_rows.size() == 0) begin
                    $error("pixel row with nothing expected: row %0d", m_row_number);
                    fail_tally++;
                end else begin
                    want = expected_rows.pop_front();
                    if (!field_ok("pixel_zero", want.px[0], got.px[0])) fail_tally++;
                    if (!field_ok("pixel_one", want.px[1], got.px[1])) fail_tally++;
                    if (!field_ok("pixel_two", want.px[2], got.px[2])) fail_tally++;
                    if (!field_ok("pixel_three", want.px[3], got.px[3])) fail_tally++;
                    if (!field_ok("row_number", 32'(want.row), 32'(got.row))) fail_tally++;
                    if (!field_ok("last_row", 32'(want.last), 32'(got.last))) fail_tally++;
                end
            end
            if (s_valid && s_ready) begin
                decode_block(s_endpoint_a, s_endpoint_b, s_index_word, s_alpha_word);
            end
        end
        rows_pending   <= expected_rows.size();
        mismatch_count <= fail_tally;
    end

endmodule

>>> tb/dxt_block_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_block_decoder_tb
// Drives compressed blocks into the decoder under several alpha modes and
// block sizes, with random idling on both channels, a long output stall and
// a full drain, while the checker predicts and compares every pixel row.
// ----------------------------------------------------------------------------
module dxt_block_decoder_tb;
    import dxt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_write_enable;
    logic [1:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_endpoint_a;
    logic [15:0] s_endpoint_b;
    logic [31:0] s_index_word;
    logic [63:0] s_alpha_word;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_pixel_zero;
    logic [31:0] m_pixel_one;
    logic [31:0] m_pixel_two;
    logic [31:0] m_pixel_three;
    logic [1:0]  m_row_number;
    logic        m_last_row;

    int mismatch_count;
    int rows_pending;
    int idle_cycles = 0;
    bit tx_gaps     = 1'b0;
    bit rx_gaps     = 1'b0;
    bit hold_req    = 1'b0;

    dxt_block_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_endpoint_a     (s_endpoint_a),
        .s_endpoint_b     (s_endpoint_b),
        .s_index_word     (s_index_word),
        .s_alpha_word     (s_alpha_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_zero     (m_pixel_zero),
        .m_pixel_one      (m_pixel_one),
        .m_pixel_two      (m_pixel_two),
        .m_pixel_three    (m_pixel_three),
        .m_row_number     (m_row_number),
        .m_last_row       (m_last_row)
    );

    dxt_block_decoder_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_endpoint_a     (s_endpoint_a),
        .s_endpoint_b     (s_endpoint_b),
        .s_index_word     (s_index_word),
        .s_alpha_word     (s_alpha_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_zero     (m_pixel_zero),
        .m_pixel_one      (m_pixel_one),
        .m_pixel_two      (m_pixel_two),
        .m_pixel_three    (m_pixel_three),
        .m_row_number     (m_row_number),
        .m_last_row       (m_last_row),
        .mismatch_count   (mismatch_count),
        .rows_pending     (rows_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Row receiver: random stalls, plus one long hold on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dxt_block_decoder regression: fail");
            $finish;
        end
    end

    // Write all three registers on consecutive cycles; call only when drained
    task automatic set_config(input logic [2:0] mode_data, input logic [2:0] width,
                              input logic [2:0] height);
        cfg_write_enable <= 1'b1;
        cfg_index        <= CFG_ALPHA_MODE;
        cfg_data         <= mode_data;
        @(posedge aclk);
        cfg_index        <= CFG_BLOCK_WIDTH;
        cfg_data         <= width;
        @(posedge aclk);
        cfg_index        <= CFG_BLOCK_HEIGHT;
        cfg_data         <= height;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
    endtask

    // Offer one block and hold it until accepted; valid stays high afterwards
    task automatic send_block(input logic [15:0] ea, input logic [15:0] eb,
                              input logic [31:0] idx, input logic [63:0] alpha);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_endpoint_a <= ea;
        s_endpoint_b <= eb;
        s_index_word <= idx;
        s_alpha_word <= alpha;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic send_random_block();
        logic [15:0] ea;
        logic [15:0] eb;
        ea = 16'($urandom);
        eb = ($urandom_range(0, 7) == 0) ? ea : 16'($urandom);
        send_block(ea, eb, $urandom, {$urandom, $urandom});
    endtask

    // Stop offering and wait until every expected row has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rows_pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [2:0] w;
        logic [2:0] h;
        w = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        h = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        set_config(3'($urandom_range(0, 7)), w, h);
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= CFG_ALPHA_MODE;
        cfg_data         <= 3'd0;
        s_valid          <= 1'b0;
        s_endpoint_a     <= 16'd0;
        s_endpoint_b     <= 16'd0;
        s_index_word     <= 32'd0;
        s_alpha_word     <= 64'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: punch-through alpha, full 4x4 block
        send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 64'd0);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(16'h8410, 16'h8410, 32'hFFFFFFFF, 64'd0);
        send_block(16'hF800, 16'h07E0, 32'h1B1B1B1B, 64'd0);
        send_block(16'h001F, 16'h0000, 32'h00000000, 64'd0);
        send_block(16'h0001, 16'h0000, 32'h55AAFF00, 64'd0);
        wait_drained();

        set_config(3'b001, 3'd4, 3'd4);
        send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 64'hFEDC_BA98_7654_3210);
        send_block(16'h0000, 16'hFFFF, 32'hFFFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(16'h07E0, 16'hF800, 32'h39C6D2B4, 64'd0);
        send_random_block();
        wait_drained();

        // Zero sizes act as one
        set_config(3'b001, 3'd0, 3'd0);
        send_random_block();
        send_random_block();
        wait_drained();

        // Sizes above four act as four
        set_config(3'b000, 3'd7, 3'd7);
        send_block(16'h1234, 16'hABCD, 32'hFFFFFFFF, 64'd0);
        send_random_block();
        wait_drained();

        set_config(3'b001, 3'd2, 3'd3);
        send_block(16'hABCD, 16'h1234, 32'h9C9C9C9C, 64'h0123_4567_89AB_CDEF);
        send_random_block();
        send_random_block();
        wait_drained();

        set_config(3'b000, 3'd3, 3'd1);
        send_random_block();
        send_random_block();
        wait_drained();

        // Random phases, each with its own settings and idling
        for (int p = 0; p < 7; p++) begin
            random_config();
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            repeat (15) send_random_block();
            wait_drained();
        end

        // Hold the row output for a long stretch while blocks keep coming
        set_config(3'($urandom_range(0, 1)), 3'd4, 3'd4);
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (16) send_random_block();
        wait_drained();

        // Closing stretch at full rate
        random_config();
        repeat (10) send_random_block();
        wait_drained();
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0 && rows_pending == 0) begin
            $display("dxt_block_decoder regression: pass");
        end else begin
            $display("dxt_block_decoder regression: fail");
        end
        $finish;
    end

endmodule
